>>> src/dlsq_pkg.sv
`timescale 1ns / 1ps
package dlsq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned TID_W         = 8;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned STATUS_W      = 2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SLEEP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WOKEN   = 2'd3;

  typedef struct packed {
    logic                accept;
    logic                rd_link;
    logic                walk_step;
    logic                walk_end;
    logic                scan_en;
    logic                ins_first;
    logic                ins_second;
    logic                tick_wr;
    logic                pop;
    logic                out_load;
    logic                out_wake;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } dlsq_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic in_time_zero;
    logic full;
    logic empty;
    logic walk_go;
    logic slot_found;
    logic dec_zero;
    logic wake_more;
    logic out_free;
  } dlsq_stat_t;

endpackage

>>> src/delta_list_sleep_queue.sv
`timescale 1ns / 1ps
// delta-list sleep queue
// input channel (in_valid_i / in_ready_o): cmd_i selects a timer tick or a
// sleep request carrying thread_id_i and sleep_time_i
// output channel (out_valid_o / out_ready_i): thread_out_o, status_o, last_o;
// every sleep request gives one transaction (queued, ignored or refused), a
// tick gives one woken transaction per expired thread, last_o on the final one
// a sleep request walks the list with one list-memory read per entry passed;
// a free-slot scan runs beside it, then the write-back states S_INS1 and
// S_INS2 and the response follow; ignored or refused requests go straight
// to the response; a tick decrements the head delta, then wakes expired
// threads in turn; an empty-queue tick gives no transaction
// one item is worked at a time; the next is accepted as soon as the previous
// one's last result sits in the output register
// a stalled receiver holds the output register and the block waits in place
// reset empties the list at once: head, fill count and free mask are flops,
// so there is no clearing pass
module delta_list_sleep_queue #(
  parameter int unsigned QUEUE_DEPTH = dlsq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [dlsq_pkg::TID_W-1:0]    thread_id_i,
  input  logic [dlsq_pkg::TIME_W-1:0]   sleep_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dlsq_pkg::TID_W-1:0]    thread_out_o,
  output logic [dlsq_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import dlsq_pkg::*;

  dlsq_cmd_t  cmd;
  dlsq_stat_t stat;

  dlsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dlsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .thread_id_i  (thread_id_i),
    .sleep_time_i (sleep_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .thread_out_o (thread_out_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .cmd_in_i     (cmd),
    .stat_o       (stat)
  );

endmodule

>>> src/dlsq_ctrl.sv
`timescale 1ns / 1ps
module dlsq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dlsq_pkg::dlsq_stat_t stat_i,
  output dlsq_pkg::dlsq_cmd_t  cmd_o
);
  import dlsq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_INS1  = 3'd3;
  localparam logic [2:0] S_INS2  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;
  localparam logic [2:0] S_TICK  = 3'd6;
  localparam logic [2:0] S_WAKE  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [STATUS_W-1:0] resp_q, resp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= ST_QUEUED;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    resp_d     = resp_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_cmd == CMD_SLEEP) begin
            if (stat_i.in_time_zero) begin
              resp_d  = ST_IGNORED;
              state_d = S_RESP;
            end else if (stat_i.full) begin
              resp_d  = ST_REFUSED;
              state_d = S_RESP;
            end else begin
              state_d = S_WALK;
            end
          end else if (!stat_i.empty) begin
            state_d = S_TICK;
          end
        end
      end
      S_WALK: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.walk_go) begin
          cmd_o.walk_step = 1'b1;
          cmd_o.rd_link   = 1'b1;
        end else begin
          cmd_o.walk_end = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.slot_found) begin
          state_d = S_INS1;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      S_INS1: begin
        cmd_o.ins_first = 1'b1;
        state_d         = S_INS2;
      end
      S_INS2: begin
        cmd_o.ins_second = 1'b1;
        resp_d           = ST_QUEUED;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = resp_q;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_TICK: begin
        cmd_o.tick_wr = 1'b1;
        if (stat_i.dec_zero) begin
          cmd_o.pop     = 1'b1;
          cmd_o.rd_link = 1'b1;
          state_d       = S_WAKE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WAKE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_wake   = 1'b1;
          cmd_o.out_status = ST_WOKEN;
          cmd_o.out_last   = !stat_i.wake_more;
          if (stat_i.wake_more) begin
            cmd_o.pop     = 1'b1;
            cmd_o.rd_link = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> src/dlsq_datapath.sv
`timescale 1ns / 1ps
module dlsq_datapath #(
  parameter int unsigned QUEUE_DEPTH = dlsq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_i,
  input  logic [dlsq_pkg::TID_W-1:0]    thread_id_i,
  input  logic [dlsq_pkg::TIME_W-1:0]   sleep_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dlsq_pkg::TID_W-1:0]    thread_out_o,
  output logic [dlsq_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o,
  input  dlsq_pkg::dlsq_cmd_t           cmd_in_i,
  output dlsq_pkg::dlsq_stat_t          stat_o
);
  import dlsq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  // list storage, one write and one registered read per cycle each
  logic [TIME_W-1:0] delta_mem  [QUEUE_DEPTH];
  logic [TID_W-1:0]  thread_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]  link_mem   [QUEUE_DEPTH];

  logic [TIME_W-1:0] rd_delta_q;
  logic [TID_W-1:0]  rd_thread_q;
  logic [IDX_W-1:0]  rd_link_q;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]       head_q;
  logic [OCC_W-1:0]       occ_q;
  logic [QUEUE_DEPTH-1:0] free_q;
  logic [OCC_W-1:0]       k_q;
  logic [TIME_W-1:0]      rem_q;
  logic [TIME_W-1:0]      cdelta_q;
  logic [IDX_W-1:0]       cur_q;
  logic [IDX_W-1:0]       prev_q;
  logic                   has_prev_q;
  logic                   has_next_q;
  logic [IDX_W-1:0]       scan_q;
  logic [TID_W-1:0]       tid_q;
  logic [TID_W-1:0]       pend_q;

  logic                   out_valid_q;
  logic [TID_W-1:0]       out_thread_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic                   out_last_q;

  logic              dwr_en;
  logic [IDX_W-1:0]  dwr_addr;
  logic [TIME_W-1:0] dwr_data;
  logic              lwr_en;
  logic [IDX_W-1:0]  lwr_addr;
  logic [IDX_W-1:0]  lwr_data;
  logic [TIME_W-1:0] dec_delta;

  assign rd_addr   = cmd_in_i.rd_link ? rd_link_q : head_q;
  assign dec_delta = (rd_delta_q == '0) ? '0 : rd_delta_q - TIME_W'(1);

  always_comb begin
    dwr_en   = 1'b0;
    dwr_addr = scan_q;
    dwr_data = rem_q;
    lwr_en   = 1'b0;
    lwr_addr = scan_q;
    lwr_data = has_next_q ? cur_q : '0;
    if (cmd_in_i.ins_first) begin
      dwr_en = 1'b1;
      lwr_en = 1'b1;
    end else if (cmd_in_i.ins_second) begin
      dwr_en   = has_next_q;
      dwr_addr = cur_q;
      dwr_data = cdelta_q - rem_q;
      lwr_en   = has_prev_q;
      lwr_addr = prev_q;
      lwr_data = scan_q;
    end else if (cmd_in_i.tick_wr) begin
      dwr_en   = 1'b1;
      dwr_addr = head_q;
      dwr_data = dec_delta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwr_en) begin
      delta_mem[dwr_addr] <= dwr_data;
    end
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (cmd_in_i.ins_first) begin
      thread_mem[scan_q] <= tid_q;
    end
    rd_delta_q  <= delta_mem[rd_addr];
    rd_thread_q <= thread_mem[rd_addr];
    rd_link_q   <= link_mem[rd_addr];
  end

  // list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      free_q <= '1;
    end else begin
      if (cmd_in_i.ins_first) begin
        free_q[scan_q] <= 1'b0;
        occ_q          <= occ_q + OCC_W'(1);
      end else if (cmd_in_i.pop) begin
        free_q[head_q] <= 1'b1;
        occ_q          <= occ_q - OCC_W'(1);
      end
      if (cmd_in_i.pop) begin
        head_q <= rd_link_q;
      end else if (cmd_in_i.ins_second && !has_prev_q) begin
        head_q <= scan_q;
      end
    end
  end

  // walk and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.accept) begin
      tid_q      <= thread_id_i;
      rem_q      <= sleep_time_i;
      cur_q      <= head_q;
      k_q        <= '0;
      has_prev_q <= 1'b0;
      scan_q     <= '0;
    end else begin
      if (cmd_in_i.walk_step) begin
        rem_q      <= rem_q - rd_delta_q;
        prev_q     <= cur_q;
        has_prev_q <= 1'b1;
        cur_q      <= rd_link_q;
        k_q        <= k_q + OCC_W'(1);
      end
      if (cmd_in_i.walk_end) begin
        cdelta_q   <= rd_delta_q;
        has_next_q <= (k_q < occ_q);
      end
      if (cmd_in_i.scan_en && !free_q[scan_q]) begin
        scan_q <= scan_q + IDX_W'(1);
      end
    end
    if (cmd_in_i.pop) begin
      pend_q <= rd_thread_q;
    end
  end

  // output register, parts the two sides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_in_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.out_load) begin
      out_thread_q <= cmd_in_i.out_wake ? pend_q : tid_q;
      out_status_q <= cmd_in_i.out_status;
      out_last_q   <= cmd_in_i.out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign thread_out_o = out_thread_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

  assign stat_o.in_cmd       = cmd_i;
  assign stat_o.in_time_zero = (sleep_time_i == '0);
  assign stat_o.full         = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign stat_o.empty        = (occ_q == '0);
  assign stat_o.walk_go      = (k_q < occ_q) && (rd_delta_q <= rem_q);
  assign stat_o.slot_found   = free_q[scan_q];
  assign stat_o.dec_zero     = (rd_delta_q <= TIME_W'(1));
  assign stat_o.wake_more    = (occ_q != '0) && (rd_delta_q == '0);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

endmodule

>>> bench/tb_delta_list_sleep_queue.sv
`timescale 1ns / 1ps
module tb_delta_list_sleep_queue;
  import dlsq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int N_DIR       = 25;
  localparam int N_RAND      = 355;
  localparam int HOLD_AT     = 100;
  localparam int PAUSE_AT    = 230;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [TID_W-1:0]    thread;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // typed_n < 0: expectation comes from the predictor
  typedef struct {
    logic              cmd;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] ticks;
    int                typed_n;
    result_t           typed;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                cmd_i;
  logic [TID_W-1:0]    thread_id_i;
  logic [TIME_W-1:0]   sleep_time_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [TID_W-1:0]    thread_out_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  delta_list_sleep_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .thread_id_i  (thread_id_i),
    .sleep_time_i (sleep_time_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .thread_out_o (thread_out_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // predictor state: delta-linked list of sleepers
  logic [TIME_W-1:0] slot_delta [DEPTH];
  logic [TID_W-1:0]  slot_tid   [DEPTH];
  int                slot_next  [DEPTH];
  int                head_idx;
  logic [DEPTH-1:0]  free_mask;
  int                fill;

  result_t due_results [$];
  result_t no_result = '{8'h00, ST_QUEUED, 1'b0};
  bit      hold_req;
  int      errors;
  int      n_items, n_sleeps, n_results, n_woken, n_refused, n_ignored, peak_fill;

  row_t dir_rows [N_DIR] = '{
    '{CMD_TICK,  8'h00, 32'h0000_0000, 0,  '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'hFF, 32'h0000_0000, 1,  '{8'hFF, ST_IGNORED, 1'b1}},
    '{CMD_SLEEP, 8'h00, 32'hFFFF_FFFF, 1,  '{8'h00, ST_QUEUED,  1'b1}},
    '{CMD_SLEEP, 8'hA5, 32'd3,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h5A, 32'd3,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h01, 32'd1,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_TICK,  8'h00, 32'h0000_0000, -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_TICK,  8'hFF, 32'hFFFF_FFFF, -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_TICK,  8'h00, 32'h0000_0000, -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h80, 32'd2,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h40, 32'd2,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h20, 32'd7,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h10, 32'd5,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h08, 32'd7,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h04, 32'd1,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h02, 32'd1,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h7F, 32'h8000_0000, -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'hF0, 32'd4,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h0F, 32'd6,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h33, 32'd2,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'hCC, 32'd3,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h55, 32'd9,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'hAA, 32'hFFFF_FFFF, -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h99, 32'd1,         -1, '{8'h00, ST_QUEUED,  1'b0}},
    '{CMD_SLEEP, 8'h66, 32'h7FFF_FFFF, 1,  '{8'h66, ST_REFUSED, 1'b1}}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d transactions still due", due_results.size());
    $display("tb_delta_list_sleep_queue NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // mostly no gap, some short, a few long
  function automatic int next_gap(input bit calm);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one command against the list: insert, ignore or refuse, or tick and collect wakeups
  task automatic queue_advance(input logic c, input logic [TID_W-1:0] tid,
                               input logic [TIME_W-1:0] ticks, ref result_t res[$]);
    logic [TIME_W-1:0] rem;
    int cur, prev, k, slot;
    bit has_prev;
    res.delete();
    if (c == CMD_SLEEP) begin
      if (ticks == '0) begin
        res.push_back(result_t'{tid, ST_IGNORED, 1'b1});
      end else if (fill >= DEPTH || free_mask == '0) begin
        res.push_back(result_t'{tid, ST_REFUSED, 1'b1});
      end else begin
        rem = ticks;
        cur = head_idx;
        prev = 0;
        has_prev = 0;
        k = 0;
        // equal wake times go behind the existing entries
        while (k < fill && slot_delta[cur] <= rem) begin
          rem -= slot_delta[cur];
          prev = cur;
          has_prev = 1;
          cur = slot_next[cur];
          k++;
        end
        slot = 0;
        while (!free_mask[slot]) slot++;
        free_mask[slot] = 1'b0;
        slot_delta[slot] = rem;
        slot_tid[slot] = tid;
        if (k < fill) begin
          slot_next[slot] = cur;
          slot_delta[cur] -= rem;
        end else begin
          slot_next[slot] = 0;
        end
        if (has_prev) slot_next[prev] = slot;
        else head_idx = slot;
        fill++;
        res.push_back(result_t'{tid, ST_QUEUED, 1'b1});
      end
    end else if (fill != 0) begin
      if (slot_delta[head_idx] != '0) slot_delta[head_idx]--;
      while (fill > 0 && slot_delta[head_idx] == '0) begin
        res.push_back(result_t'{slot_tid[head_idx], ST_WOKEN, 1'b0});
        free_mask[head_idx] = 1'b1;
        head_idx = slot_next[head_idx];
        fill--;
      end
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(input logic c, input logic [TID_W-1:0] tid,
                       input logic [TIME_W-1:0] ticks, input int gap,
                       input int typed_n, input result_t typed);
    result_t got [$];
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    thread_id_i  <= tid;
    sleep_time_i <= ticks;
    do @(posedge clk_i); while (!in_ready_o);
    queue_advance(c, tid, ticks, got);
    n_items++;
    if (c == CMD_SLEEP) n_sleeps++;
    foreach (got[k]) begin
      n_results++;
      case (got[k].status)
        ST_WOKEN:   n_woken++;
        ST_REFUSED: n_refused++;
        ST_IGNORED: n_ignored++;
        default: ;
      endcase
    end
    if (typed_n < 0) begin
      foreach (got[k]) due_results.push_back(got[k]);
    end else if (typed_n == 1) begin
      due_results.push_back(typed);
    end
    if (fill > peak_fill) peak_fill = fill;
    @(negedge clk_i);
  endtask

  initial begin : drive_in
    int mode_left, tick_pct, burst_left, pick;
    bit calm_tx;
    logic c;
    logic [TID_W-1:0] tid;
    logic [TIME_W-1:0] ticks;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_TICK;
    thread_id_i  = '0;
    sleep_time_i = '0;
    hold_req     = 0;
    errors       = 0;
    head_idx     = 0;
    free_mask    = '1;
    fill         = 0;
    foreach (slot_delta[s]) begin
      slot_delta[s] = '0;
      slot_tid[s]   = '0;
      slot_next[s]  = 0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r])
      issue(dir_rows[r].cmd, dir_rows[r].tid, dir_rows[r].ticks, next_gap(0),
            dir_rows[r].typed_n, dir_rows[r].typed);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_results.size() != 0);

    mode_left  = 0;
    tick_pct   = 40;
    burst_left = 0;
    calm_tx    = 0;
    for (int i = 0; i < N_RAND; i++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       tick_pct = 20;
          1:       tick_pct = 40;
          default: tick_pct = 65;
        endcase
        calm_tx = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      // receiver goes quiet while we keep pushing
      if (i == HOLD_AT) begin
        hold_req   = 1;
        burst_left = 40;
      end
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (due_results.size() != 0);
      end
      tid = TID_W'($urandom);
      if ($urandom_range(0, 99) < tick_pct) begin
        c = CMD_TICK;
        ticks = $urandom;
      end else begin
        c = CMD_SLEEP;
        pick = $urandom_range(0, 99);
        // a full list refuses any nonzero time, so full-width times go there
        if (fill >= DEPTH) ticks = $urandom;
        else if (pick < 5) ticks = '0;
        else if (pick < 15) ticks = $urandom_range(13, 80);
        else ticks = $urandom_range(1, 12);
      end
      issue(c, tid, ticks, (burst_left > 0) ? 0 : next_gap(calm_tx), -1, no_result);
      if (burst_left > 0) burst_left--;
    end
    in_valid_i <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 10) @(posedge clk_i);
    $display("ran %0d commands (%0d sleeps, %0d ticks), %0d output transactions",
             n_items, n_sleeps, n_items - n_sleeps, n_results);
    $display("woken %0d, refused %0d, ignored %0d, peak list fill %0d of %0d",
             n_woken, n_refused, n_ignored, peak_fill, DEPTH);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb_delta_list_sleep_queue OK");
    end else begin
      $display("tb_delta_list_sleep_queue NOT OK");
    end
    $finish;
  end

  initial begin : drive_out
    int stall, calm_left;
    bit calm;
    out_ready_i = 1'b0;
    stall       = 0;
    calm_left   = 0;
    calm        = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(100, 300);
      end else begin
        calm_left--;
      end
      if (hold_req) begin
        hold_req = 0;
        stall    = HOLD_CYCLES;
      end else if (stall == 0) begin
        stall = next_gap(calm);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watch_out
    result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction thread %0h status %0d last %0b",
                                    thread_out_o, status_o, last_o));
        end else begin
          want = due_results.pop_front();
          if (thread_out_o !== want.thread)
            report_mismatch($sformatf("thread_out %0h, want %0h", thread_out_o, want.thread));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (thread %0h)",
                                      status_o, want.status, want.thread));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (thread %0h)",
                                      last_o, want.last, want.thread));
        end
      end
    end
  end

endmodule
